@@ rtl/pcd_pkg.sv @@
// Shared constants, types and helper functions for the plane dedup table.
// No dependencies; pcd_cell and the top module refer to this package by scoped names.
`default_nettype none
package pcd_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 8192;

   localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
   localparam logic signed [31:0] NEG_ONE_Q30 = -32'sh4000_0000;

   localparam logic [2:0] KIND_X        = 3'd0;
   localparam logic [2:0] KIND_Y        = 3'd1;
   localparam logic [2:0] KIND_Z        = 3'd2;
   localparam logic [2:0] KIND_MOSTLY_X = 3'd3;
   localparam logic [2:0] KIND_MOSTLY_Y = 3'd4;
   localparam logic [2:0] KIND_MOSTLY_Z = 3'd5;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_NOT_UNIT = 2'd1;
   localparam logic [1:0] ERR_FULL     = 2'd2;

   localparam logic [31:0] CSR_ANGLE_THRESHOLD  = 32'd0;
   localparam logic [31:0] CSR_OFFSET_TOLERANCE = 32'd1;

   localparam logic [30:0] ANGLE_THRESHOLD_RST  = 31'd1073731087;
   localparam logic [15:0] OFFSET_TOLERANCE_RST = 16'd164;

   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic signed [31:0] off;
   } plane_type;

   localparam int unsigned PLANE_W = $bits(plane_type);

   // one slot of the scan chain
   typedef struct packed {
      logic               valid;
      plane_type          plane;
      logic signed [63:0] acc;
   } cell_bus_type;

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      logic signed [31:0] r;
      if (v == 32'sh8000_0000) begin
         r = 32'sh7FFF_FFFF;
      end else begin
         r = -v;
      end
      return r;
   endfunction

   function automatic logic [31:0] mag(input logic signed [31:0] v);
      logic [31:0] r;
      if (v < 0) begin
         r = 32'd0 - 32'(v);
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/pcd_if.sv @@
// Handshake interfaces for the request, response and register write channels.
// Depends on nothing.
`default_nettype none
interface pcd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] normal_x;
   logic signed [31:0] normal_y;
   logic signed [31:0] normal_z;
   logic signed [31:0] plane_offset_in;
   modport source (output valid, normal_x, normal_y, normal_z, plane_offset_in, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, plane_offset_in, output ready);
endinterface

interface pcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] plane_index;
   logic        flipped_side;
   logic [2:0]  axis_kind;
   logic        newly_added;
   logic [1:0]  error_code;
   modport source (output valid, plane_index, flipped_side, axis_kind, newly_added,
                   error_code, input ready);
   modport sink   (input valid, plane_index, flipped_side, axis_kind, newly_added,
                   error_code, output ready);
endinterface

interface pcd_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/pcd_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module pcd_ram #(
   parameter int unsigned WIDTH = 128,
   parameter int unsigned DEPTH = 8192,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

@@ rtl/pcd_cell.sv @@
// One multiply-accumulate cell of the scan chain: adds one normal component
// product to the running dot product and hands the slot on. Uses pcd_pkg.
`default_nettype none
module pcd_cell #(
   parameter int unsigned LANE = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  flush,
   input  wire logic signed [31:0]    canon_comp,
   input  wire pcd_pkg::cell_bus_type bus_in,
   output pcd_pkg::cell_bus_type      bus_ff
);
   logic signed [31:0] stored_comp;
   logic signed [63:0] prod;
   pcd_pkg::cell_bus_type bus_in_next;

   always_comb begin
      case (LANE)
         0:       stored_comp = bus_in.plane.nx;
         1:       stored_comp = bus_in.plane.ny;
         default: stored_comp = bus_in.plane.nz;
      endcase
      prod = stored_comp * canon_comp;
      bus_in_next = bus_in;
      bus_in_next.valid = bus_in.valid & ~flush;
      bus_in_next.acc = bus_in.acc + prod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else begin
         bus_ff.valid <= bus_in_next.valid;
      end
      bus_ff.plane <= bus_in_next.plane;
      bus_ff.acc   <= bus_in_next.acc;
   end
endmodule
`default_nettype wire

@@ rtl/plane_canonicalize_dedup_table.sv @@
// Plane canonicalize and dedup table. A request goes through the square, canonical
// form, a scan through the registered RAM read and the three-cell chain, and the
// response load; a match at entry i ends the scan. One request at a time: the next is
// taken in the cycle after the response loads, and not before a held response is taken.
// Synchronous reset clears the plane count and control state; the table RAM is not cleared.
`default_nettype none
module plane_canonicalize_dedup_table #(
   parameter int unsigned TABLE_DEPTH = pcd_pkg::TABLE_DEPTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   pcd_req_if.sink    req_bus,
   pcd_rsp_if.source  rsp_bus,
   pcd_csr_if.sink    csr_bus
);
   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PREP  = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [30:0] thr_ff;
   logic [15:0] tol_ff;

   // captured request
   logic signed [31:0] in_x_ff, in_y_ff, in_z_ff, in_d_ff;
   logic [63:0] sq_x_ff, sq_y_ff, sq_z_ff;

   // canonical plane held during the scan
   pcd_pkg::plane_type canon_ff, canon_in;
   logic        flip_ff, flip_in;
   logic [2:0]  kind_ff, kind_in;

   // pending result
   logic [12:0] res_idx_ff, res_idx_in;
   logic        res_flip_ff, res_flip_in;
   logic [2:0]  res_kind_ff, res_kind_in;
   logic        res_new_ff, res_new_in;
   logic [1:0]  res_err_ff, res_err_in;

   logic [CW-1:0] count_ff, issue_ff, issue_in, chk_ff, chk_in;

   // response register
   logic        rsp_valid_ff;
   logic [12:0] rsp_idx_ff;
   logic        rsp_flip_ff;
   logic [2:0]  rsp_kind_ff;
   logic        rsp_new_ff;
   logic [1:0]  rsp_err_ff;

   logic req_fire, csr_fire, rsp_free;
   logic rd_en, rd_valid_ff, flush, hit, wr_en, unit_bad;
   logic [pcd_pkg::PLANE_W-1:0] rd_data;
   logic [63:0] sq_sum, dev, win;
   logic [31:0] thr_gap;
   logic signed [63:0] tdot;
   logic signed [32:0] dd;
   logic [32:0] ad;
   pcd_pkg::cell_bus_type chain [4];

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire = req_bus.valid & req_bus.ready;
   assign csr_fire = csr_bus.valid & csr_bus.ready;
   assign rsp_free = ~rsp_valid_ff | rsp_bus.ready;

   // register writes; out-of-list indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= pcd_pkg::ANGLE_THRESHOLD_RST;
         tol_ff <= pcd_pkg::OFFSET_TOLERANCE_RST;
      end else if (csr_fire) begin
         case (csr_bus.index)
            pcd_pkg::CSR_ANGLE_THRESHOLD:  thr_ff <= csr_bus.data[30:0];
            pcd_pkg::CSR_OFFSET_TOLERANCE: tol_ff <= csr_bus.data[15:0];
            default: ;
         endcase
      end
   end

   // unit length test: |s - 1.0| > 2*(1.0 - threshold), all in Q4.60
   always_comb begin
      sq_sum  = sq_x_ff + sq_y_ff + sq_z_ff;
      dev     = (sq_sum >= 64'h1000_0000_0000_0000) ? sq_sum - 64'h1000_0000_0000_0000
                                                     : 64'h1000_0000_0000_0000 - sq_sum;
      thr_gap = 32'(pcd_pkg::ONE_Q30) - {1'b0, thr_ff};
      win     = 64'(thr_gap) << 31;
      unit_bad = ({1'b0, thr_ff} > 32'(pcd_pkg::ONE_Q30)) || (dev > win);
   end

   // canonical form: fold -1 axes, pick kind, negate toward the dominant axis
   always_comb begin
      logic signed [31:0] c [3];
      logic signed [31:0] d, dom;
      logic               f;
      logic [31:0]        ax, ay, az;
      c[0] = in_x_ff;
      c[1] = in_y_ff;
      c[2] = in_z_ff;
      d = in_d_ff;
      f = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (c[k] == pcd_pkg::NEG_ONE_Q30) begin
            c[k] = pcd_pkg::ONE_Q30;
            d = pcd_pkg::neg_sat(d);
            f = ~f;
         end
      end
      ax = pcd_pkg::mag(c[0]);
      ay = pcd_pkg::mag(c[1]);
      az = pcd_pkg::mag(c[2]);
      dom = c[0];
      if (c[0] == pcd_pkg::ONE_Q30) begin
         kind_in = pcd_pkg::KIND_X;
      end else if (c[1] == pcd_pkg::ONE_Q30) begin
         kind_in = pcd_pkg::KIND_Y;
      end else if (c[2] == pcd_pkg::ONE_Q30) begin
         kind_in = pcd_pkg::KIND_Z;
      end else begin
         if (ax >= ay && ax >= az) begin
            kind_in = pcd_pkg::KIND_MOSTLY_X;
            dom = c[0];
         end else if (ay >= ax && ay >= az) begin
            kind_in = pcd_pkg::KIND_MOSTLY_Y;
            dom = c[1];
         end else begin
            kind_in = pcd_pkg::KIND_MOSTLY_Z;
            dom = c[2];
         end
         if (dom < 0) begin
            for (int k = 0; k < 3; k++) begin
               c[k] = pcd_pkg::neg_sat(c[k]);
            end
            d = pcd_pkg::neg_sat(d);
            f = ~f;
         end
      end
      canon_in.nx  = c[0];
      canon_in.ny  = c[1];
      canon_in.nz  = c[2];
      canon_in.off = d;
      flip_in = f;
   end

   // table RAM: issue one read per cycle while scanning, until every stored entry is read or a match is found
   assign rd_en = (state_ff == ST_SCAN) && (issue_ff < count_ff) && !hit;
   assign flush = (state_ff != ST_SCAN) || hit;

   pcd_ram #(.WIDTH(pcd_pkg::PLANE_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[AW-1:0]),
      .wr_data    (canon_ff),
      .rd_en      (rd_en),
      .rd_addr    (issue_ff[AW-1:0]),
      .rd_data_ff (rd_data)
   );

   always_comb begin
      chain[0].valid = rd_valid_ff;
      chain[0].plane = rd_data;
      chain[0].acc   = '0;
   end

   pcd_cell #(.LANE(0)) u_cell_x (.clock(clock), .reset(reset), .flush(flush),
      .canon_comp(canon_ff.nx), .bus_in(chain[0]), .bus_ff(chain[1]));
   pcd_cell #(.LANE(1)) u_cell_y (.clock(clock), .reset(reset), .flush(flush),
      .canon_comp(canon_ff.ny), .bus_in(chain[1]), .bus_ff(chain[2]));
   pcd_cell #(.LANE(2)) u_cell_z (.clock(clock), .reset(reset), .flush(flush),
      .canon_comp(canon_ff.nz), .bus_in(chain[2]), .bus_ff(chain[3]));

   // match test at the end of the chain; slots come out in index order
   always_comb begin
      tdot = $signed(64'({thr_ff}) << 30);
      dd   = {chain[3].plane.off[31], chain[3].plane.off} - {canon_ff.off[31], canon_ff.off};
      ad   = dd[32] ? 33'(-dd) : 33'(dd);
      hit  = (state_ff == ST_SCAN) && chain[3].valid && (chain[3].acc > tdot)
             && (ad < {17'd0, tol_ff});
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      issue_in    = issue_ff;
      chk_in      = chk_ff;
      wr_en       = 1'b0;
      res_idx_in  = res_idx_ff;
      res_flip_in = res_flip_ff;
      res_kind_in = res_kind_ff;
      res_new_in  = res_new_ff;
      res_err_in  = res_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            issue_in = '0;
            chk_in   = '0;
            if (unit_bad) begin
               res_idx_in  = '0;
               res_flip_in = 1'b0;
               res_kind_in = '0;
               res_new_in  = 1'b0;
               res_err_in  = pcd_pkg::ERR_NOT_UNIT;
               state_in    = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + 1'b1;
            end
            if (chain[3].valid) begin
               chk_in = chk_ff + 1'b1;
            end
            if (hit) begin
               res_idx_in  = 13'(chk_ff);
               res_flip_in = flip_ff;
               res_kind_in = kind_ff;
               res_new_in  = 1'b0;
               res_err_in  = pcd_pkg::ERR_OK;
               state_in    = ST_DONE;
            end else if (chk_ff == count_ff) begin
               state_in = ST_DONE;
               if (count_ff == DEPTH_C) begin
                  res_idx_in  = '0;
                  res_flip_in = 1'b0;
                  res_kind_in = '0;
                  res_new_in  = 1'b0;
                  res_err_in  = pcd_pkg::ERR_FULL;
               end else begin
                  wr_en       = 1'b1;
                  res_idx_in  = 13'(count_ff);
                  res_flip_in = flip_ff;
                  res_kind_in = kind_ff;
                  res_new_in  = 1'b1;
                  res_err_in  = pcd_pkg::ERR_OK;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         chk_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         issue_ff    <= issue_in;
         chk_ff      <= chk_in;
         rd_valid_ff <= rd_en;
         if (wr_en) begin
            count_ff <= count_ff + 1'b1;
         end
         // hold the response until taken, then load the next one
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_x_ff <= req_bus.normal_x;
         in_y_ff <= req_bus.normal_y;
         in_z_ff <= req_bus.normal_z;
         in_d_ff <= req_bus.plane_offset_in;
      end
      if (state_ff == ST_PREP) begin
         sq_x_ff <= in_x_ff * in_x_ff;
         sq_y_ff <= in_y_ff * in_y_ff;
         sq_z_ff <= in_z_ff * in_z_ff;
      end
      if (state_ff == ST_CHECK) begin
         canon_ff <= canon_in;
         flip_ff  <= flip_in;
         kind_ff  <= kind_in;
      end
      res_idx_ff  <= res_idx_in;
      res_flip_ff <= res_flip_in;
      res_kind_ff <= res_kind_in;
      res_new_ff  <= res_new_in;
      res_err_ff  <= res_err_in;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_idx_ff  <= res_idx_ff;
         rsp_flip_ff <= res_flip_ff;
         rsp_kind_ff <= res_kind_ff;
         rsp_new_ff  <= res_new_ff;
         rsp_err_ff  <= res_err_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.plane_index  = rsp_idx_ff;
   assign rsp_bus.flipped_side = rsp_flip_ff;
   assign rsp_bus.axis_kind    = rsp_kind_ff;
   assign rsp_bus.newly_added  = rsp_new_ff;
   assign rsp_bus.error_code   = rsp_err_ff;

   // the count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C) else $error("plane count past table depth");

   // an appended plane always carries no error
   a_new_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_new_ff |-> rsp_err_ff == pcd_pkg::ERR_OK)
      else $error("append reported with an error");

   // each append grows the count by exactly one
   a_append: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not advance the count");

   // a hit can only come from an entry below the count
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      hit |-> chk_ff < count_ff) else $error("match beyond stored planes");
endmodule
`default_nettype wire
